/* rtl/klme_pkg.sv */
// Package with the shared constants, types and opcode codes of the keyed list table engine.
package klme_pkg;

  localparam int NumElements = 256;
  localparam int PoolDepth   = 1024;
  localparam int KeyWidth    = 32;
  localparam int ValueWidth  = 32;
  localparam int ElemAw      = 8;
  localparam int NodeAw      = 10;
  localparam int PtrW        = 11;
  localparam int CntW        = 11;

  localparam logic [PtrW-1:0] Nil = PtrW'(PoolDepth);

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_REM_ELEM = 3'd1,
    OP_REM_KEY  = 3'd2,
    OP_LOOKUP   = 3'd3,
    OP_COUNT    = 3'd4,
    OP_CLEAR    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_HEAD,
    S_HEAD_WAIT,
    S_READ,
    S_WALK,
    S_ACT,
    S_FREEPOP,
    S_FREEPOP_WAIT,
    S_WRITE2,
    S_DONE
  } state_t;

endpackage

/* rtl/klme_ram.sv */
// Generic single-port RAM with a registered read.
module klme_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/keyed_list_multimap_engine_top.sv */
// Top level of the keyed list table engine: sequencer, chain walk and node memories.
//
// The block keeps one linked chain of key/value nodes for each of 256 elements, drawn from
// a shared pool of 1024 nodes with a free list. Raise start with an item while busy is low;
// busy then stays high until the item is done, and the result appears for exactly one cycle
// with out_valid high, in the first cycle in which busy is low again. The receiver cannot
// stall, so it must take the result in that cycle. The time for one item is set by the
// chain walk through the node memory: each node is addressed in S_READ, and its registered
// read is examined in S_WALK. A key operation stops the walk at the first node whose key
// matches; a count, a remove element or a missing key walks the whole chain. An insert
// of a new key that takes a node from the free list first pops it through S_FREEPOP and
// S_FREEPOP_WAIT; a never-used node goes straight to S_WRITE2. An unused opcode goes
// straight to S_DONE. After reset, and for every clear, the block sweeps the 256 chain
// heads, one a cycle, and takes no item until the sweep is done; the sweep after reset
// gives no result. Node contents are never cleared: a node is only read after it has been
// handed out and written.
module keyed_list_multimap_engine_top
  import klme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_opcode,
  input  logic [7:0]            in_element,
  input  logic [KeyWidth-1:0]   in_key,
  input  logic [ValueWidth-1:0] in_value_in,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic                  out_found,
  output logic [31:0]           out_value_out,
  output logic [CntW-1:0]       out_chain_count,
  output logic [CntW-1:0]       out_total_count
);

  // Sequencer state and item registers.
  state_t state_r, state_nxt;
  logic [2:0]            op_r;
  logic [ElemAw-1:0]     el_r;
  logic [KeyWidth-1:0]   key_r;
  logic [ValueWidth-1:0] val_r;
  ptr_t head_r, head_nxt;      // head of the addressed chain
  ptr_t idx_r, idx_nxt;        // node being visited
  ptr_t prev_r, prev_nxt;      // predecessor of idx_r
  ptr_t last_r, last_nxt;      // last node seen by the walk
  ptr_t newn_r, newn_nxt;      // node handed out to an insert
  cnt_t cnt_r, cnt_nxt;        // nodes walked
  ptr_t free_head_r, free_head_nxt;
  ptr_t hw_r, hw_nxt;
  cnt_t total_r, total_nxt;
  logic [ElemAw-1:0] clr_r, clr_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        found_r, found_nxt;

  // Memory ports.
  logic              head_we;
  logic [ElemAw-1:0] head_addr;
  ptr_t              head_wdata, head_rdata;
  logic              key_we;
  logic [NodeAw-1:0] node_addr;
  logic [KeyWidth-1:0]   key_rdata, key_wdata;
  logic [ValueWidth-1:0] val_rdata, val_wdata;
  logic              val_we, link_we;
  ptr_t              link_wdata, link_rdata;

  klme_ram #(.Width(PtrW), .Depth(NumElements)) u_head (
    .clk(clk), .we(head_we), .addr(head_addr), .wdata(head_wdata), .rdata(head_rdata));
  klme_ram #(.Width(KeyWidth), .Depth(PoolDepth)) u_key (
    .clk(clk), .we(key_we), .addr(node_addr), .wdata(key_wdata), .rdata(key_rdata));
  klme_ram #(.Width(ValueWidth), .Depth(PoolDepth)) u_val (
    .clk(clk), .we(val_we), .addr(node_addr), .wdata(val_wdata), .rdata(val_rdata));
  klme_ram #(.Width(PtrW), .Depth(PoolDepth)) u_link (
    .clk(clk), .we(link_we), .addr(node_addr), .wdata(link_wdata), .rdata(link_rdata));

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Range check is folded in at accept time.
  logic range_bad;
  assign range_bad = (32'(in_element) >= 32'(NumElements));

  // Set from reset until the first item is taken; the power-on sweep gives no result.
  logic from_reset_r;

  // The single compare unit: the key of the node just read against the item's key.
  logic key_hit;
  assign key_hit = (key_rdata == key_r);

  logic is_key_op;
  assign is_key_op = (op_r == OP_INSERT) || (op_r == OP_REM_KEY) || (op_r == OP_LOOKUP);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_CLEAR) begin
            state_nxt = S_CLEAR;
          end else if (in_opcode > OP_CLEAR || range_bad) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_HEAD;
          end
        end
      end
      S_CLEAR: begin
        if (clr_r == ElemAw'(NumElements - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_HEAD:      state_nxt = S_HEAD_WAIT;
      S_HEAD_WAIT: state_nxt = S_READ;
      S_READ: begin
        if (idx_r == Nil || cnt_r == CntW'(PoolDepth)) begin
          state_nxt = S_ACT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (is_key_op && key_hit) begin
          state_nxt = S_ACT;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_ACT: begin
        if (op_r == OP_INSERT && idx_r == Nil && free_head_r != Nil) begin
          state_nxt = S_FREEPOP;
        end else if (op_r == OP_INSERT && idx_r == Nil && hw_r != Nil) begin
          state_nxt = S_WRITE2;
        end else if (op_r == OP_REM_KEY && idx_r != Nil) begin
          state_nxt = S_WRITE2;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FREEPOP:      state_nxt = S_FREEPOP_WAIT;
      S_FREEPOP_WAIT: state_nxt = S_WRITE2;
      S_WRITE2:       state_nxt = S_DONE;
      S_DONE:         state_nxt = S_IDLE;
      default:        state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    head_nxt      = head_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    last_nxt      = last_r;
    newn_nxt      = newn_r;
    cnt_nxt       = cnt_r;
    free_head_nxt = free_head_r;
    hw_nxt        = hw_r;
    total_nxt     = total_r;
    clr_nxt       = clr_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    head_we       = 1'b0;
    head_addr     = el_r;
    head_wdata    = Nil;
    key_we        = 1'b0;
    val_we        = 1'b0;
    link_we       = 1'b0;
    node_addr     = idx_r[NodeAw-1:0];
    key_wdata     = key_r;
    val_wdata     = val_r;
    link_wdata    = Nil;
    case (state_r)
      S_IDLE: begin
        status_nxt = ST_OK;
        found_nxt  = 1'b0;
        cnt_nxt    = '0;
        clr_nxt    = '0;
        prev_nxt   = Nil;
        last_nxt   = Nil;
        if (accept && in_opcode == OP_CLEAR) begin
          free_head_nxt = Nil;
          hw_nxt        = '0;
          total_nxt     = '0;
        end
      end
      S_CLEAR: begin
        head_we   = 1'b1;
        head_addr = clr_r;
        clr_nxt   = clr_r + 1'b1;
      end
      S_HEAD: head_addr = el_r;
      S_HEAD_WAIT: begin
        head_nxt = head_rdata;
        idx_nxt  = head_rdata;
      end
      S_READ: node_addr = idx_r[NodeAw-1:0];
      S_WALK: begin
        node_addr = idx_r[NodeAw-1:0];
        if (!(is_key_op && key_hit)) begin
          cnt_nxt  = cnt_r + 1'b1;
          last_nxt = idx_r;
          prev_nxt = idx_r;
          idx_nxt  = link_rdata;
        end
      end
      S_ACT: begin
        if (cnt_r == CntW'(PoolDepth) && is_key_op) begin
          idx_nxt = Nil;
        end
        case (op_r)
          OP_INSERT: begin
            if (idx_r != Nil && cnt_r != CntW'(PoolDepth)) begin
              found_nxt = 1'b1;
              val_we    = 1'b1;
            end else if (free_head_r != Nil) begin
              newn_nxt = free_head_r;
            end else if (hw_r != Nil) begin
              newn_nxt = hw_r;
              hw_nxt   = hw_r + 1'b1;
            end else begin
              status_nxt = ST_POOL_FULL;
            end
          end
          OP_REM_ELEM: begin
            if (last_r != Nil) begin
              node_addr     = last_r[NodeAw-1:0];
              link_we       = 1'b1;
              link_wdata    = free_head_r;
              free_head_nxt = head_r;
              head_we       = 1'b1;
              total_nxt     = (total_r >= cnt_r) ? total_r - cnt_r : '0;
            end
          end
          OP_REM_KEY, OP_LOOKUP: begin
            if (idx_r == Nil || cnt_r == CntW'(PoolDepth)) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              found_nxt = 1'b1;
              if (op_r == OP_REM_KEY) begin
                // Predecessor (or chain head) skips the removed node.
                if (prev_r != Nil) begin
                  node_addr  = prev_r[NodeAw-1:0];
                  link_we    = 1'b1;
                  link_wdata = link_rdata;
                end else begin
                  head_we    = 1'b1;
                  head_wdata = link_rdata;
                end
                if (total_r != '0) begin
                  total_nxt = total_r - 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_FREEPOP: node_addr = free_head_r[NodeAw-1:0];
      S_FREEPOP_WAIT: free_head_nxt = link_rdata;
      S_WRITE2: begin
        if (op_r == OP_INSERT) begin
          node_addr  = newn_r[NodeAw-1:0];
          key_we     = 1'b1;
          val_we     = 1'b1;
          link_we    = 1'b1;
          link_wdata = head_r;
          head_we    = 1'b1;
          head_wdata = newn_r;
          total_nxt  = total_r + 1'b1;
        end else begin
          // Removed node goes to the head of the free list.
          node_addr     = idx_r[NodeAw-1:0];
          link_we       = 1'b1;
          link_wdata    = free_head_r;
          free_head_nxt = idx_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= Nil;
      hw_r        <= '0;
      total_r     <= '0;
      status_r    <= ST_OK;
      found_r     <= 1'b0;
      op_r        <= 3'(OP_CLEAR);
      cnt_r       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
      total_r     <= total_nxt;
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      out_valid   <= (state_r == S_DONE) && !from_reset_r;
      if (accept) begin
        op_r <= in_opcode;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    idx_r  <= idx_nxt;
    prev_r <= prev_nxt;
    last_r <= last_nxt;
    newn_r <= newn_nxt;
    if (accept) begin
      el_r  <= in_element;
      key_r <= in_key;
      val_r <= in_value_in;
    end
  end

  // Result registers; the result of the power-on clear sweep is suppressed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_reset_r <= 1'b1;
    end else if (accept) begin
      from_reset_r <= 1'b0;
    end
  end

  logic range_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      range_r <= range_bad && in_opcode < OP_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_status      <= range_r ? ST_RANGE : status_r;
      out_found       <= range_r ? 1'b0 : found_r;
      out_value_out   <= (!range_r && op_r == OP_LOOKUP && found_r) ? 32'(val_rdata) : '0;
      out_chain_count <= (!range_r && op_r == OP_COUNT) ? cnt_r : '0;
      out_total_count <= total_r;
    end
  end

endmodule
